/* hw/rtl/dps_pkg.sv */
// Shared types and constants for the dual-pivot sort engine.
// Used by the top level and by the shared compare unit; depends on nothing.
package dps_pkg;

	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_ITEMS);
	localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

	typedef logic signed [VALUE_BITS-1:0] val_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [IDX_W:0]               ext_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	localparam cnt_t MAX_CNT = CNT_W'(MAX_ITEMS);

	// One pending subrange on the range stack.
	typedef struct packed {
		idx_t lo;
		idx_t hi;
	} range_t;

	// Result of the shared compare unit.
	typedef struct packed {
		logic lt_lo;
		logic gt_hi;
	} cmp_res_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT,
		ST_POP,
		ST_POPW,
		ST_RDHI,
		ST_PIV,
		ST_PIV2,
		ST_LOOP,
		ST_CMP,
		ST_SW1,
		ST_SW2,
		ST_FIN,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_F4,
		ST_PUSH,
		ST_ERD,
		ST_ELD,
		ST_EWAIT
	} state_t;

endpackage

/* hw/rtl/dps_cmp.sv */
// Shared compare unit: tests one value against the low and the high pivot.
// Depends on dps_pkg.
module dps_cmp import dps_pkg::*; (
	input  val_t     x,
	input  val_t     lo_piv,
	input  val_t     hi_piv,
	output cmp_res_t res
);

	always_comb begin
		res.lt_lo = (x < lo_piv);
		res.gt_hi = (x > hi_piv);
	end

endmodule

/* hw/rtl/dual_pivot_sort_engine_top.sv */
// Dual-pivot quicksort engine: load, in-place sort with a range stack, emit.
// Depends on dps_pkg and dps_cmp.
//
// Usage: signed 32-bit values arrive as beats on the s_* channel, one per
// cycle while s_tready is high. The beat with s_tlast set closes the set and
// starts the sort. Beats beyond 64 stored values are dropped and the overflow
// flag (m_tuser) is set on every output beat of that set.
// After the sort, the values leave on the m_* channel in ascending order, the
// final one with m_tlast set. s_tready stays low from the last input beat
// until the final output beat is taken.
// Each partition step goes through one shared compare unit and an element
// memory with one write port and one registered read port: an element that
// stays put is only read and compared, one that is swapped is also written
// back in ST_SW1 and ST_SW2. Each range popped from the stack also passes
// through pivot setup, fix-up and push states. Each output value is read
// from memory only after the beat before it has been taken.
// A stalled receiver simply holds the current output beat in its register.
// Reset empties the engine; memory contents need no clearing.
module dual_pivot_sort_engine_top import dps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sorted_value
	output logic        m_tlast,
	output logic        m_tuser    // [0] overflow
);

	state_t state_q, state_nx;

	val_t   mem [MAX_ITEMS];
	range_t stk [MAX_ITEMS];

	val_t   rd_q;
	range_t stk_rd_q;
	cnt_t   cnt_q, sp_q;
	logic   drop_q;
	idx_t   lo_q, hi_q, lt_q, gt_q, k_q;
	val_t   a_q, b_q, x_q;
	logic   sw_lt_q;
	logic [1:0] ph_q;
	val_t   out_data_q;
	logic   out_valid_q, out_last_q, out_ovf_q;

	logic   mem_we;
	idx_t   mem_waddr, mem_raddr;
	val_t   mem_wdata;
	logic   stk_we;
	idx_t   stk_waddr, stk_raddr;
	range_t stk_wdata;
	val_t   cmp_x, cmp_lo, cmp_hi;
	cmp_res_t cmp;
	logic   in_acc;

	ext_t   span0, span1, span2, span_big;
	logic [1:0] big, sel;
	range_t r_sel;
	ext_t   span_sel;

	dps_cmp u_cmp (
		.x      (cmp_x),
		.lo_piv (cmp_lo),
		.hi_piv (cmp_hi),
		.res    (cmp)
	);

	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	// Sizes less one of the three parts left by a partition; zero means nothing to push.
	always_comb begin
		span0 = (lt_q > lo_q) ? ({1'b0, lt_q} - {1'b0, lo_q} - ext_t'(1)) : '0;
		span1 = ({1'b0, gt_q} > ({1'b0, lt_q} + ext_t'(2)))
			? ({1'b0, gt_q} - {1'b0, lt_q} - ext_t'(2)) : '0;
		span2 = (hi_q > gt_q) ? ({1'b0, hi_q} - {1'b0, gt_q} - ext_t'(1)) : '0;
		big      = 2'd0;
		span_big = span0;
		if (span1 > span_big) begin
			big      = 2'd1;
			span_big = span1;
		end
		if (span2 > span_big) begin
			big = 2'd2;
		end
		// The largest part goes on the stack first, the other two after it.
		case (ph_q)
			2'd0:    sel = big;
			2'd1:    sel = (big == 2'd0) ? 2'd1 : 2'd0;
			default: sel = (big == 2'd2) ? 2'd1 : 2'd2;
		endcase
		case (sel)
			2'd0: begin
				r_sel    = '{lo: lo_q, hi: lt_q - idx_t'(1)};
				span_sel = span0;
			end
			2'd1: begin
				r_sel    = '{lo: lt_q + idx_t'(1), hi: gt_q - idx_t'(1)};
				span_sel = span1;
			end
			default: begin
				r_sel    = '{lo: gt_q + idx_t'(1), hi: hi_q};
				span_sel = span2;
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_LOAD:  if (in_acc && s_tlast) state_nx = ST_INIT;
			ST_INIT:  state_nx = (cnt_q < cnt_t'(2)) ? ST_ERD : ST_POP;
			ST_POP:   state_nx = (sp_q == '0) ? ST_ERD : ST_POPW;
			ST_POPW:  state_nx = ST_RDHI;
			ST_RDHI:  state_nx = ST_PIV;
			ST_PIV:   state_nx = ST_PIV2;
			ST_PIV2:  state_nx = ST_LOOP;
			ST_LOOP:  state_nx = (k_q > gt_q) ? ST_FIN : ST_CMP;
			ST_CMP:   state_nx = (cmp.lt_lo || cmp.gt_hi) ? ST_SW1 : ST_LOOP;
			ST_SW1:   state_nx = ST_SW2;
			ST_SW2:   state_nx = ST_LOOP;
			ST_FIN:   state_nx = ST_F1;
			ST_F1:    state_nx = ST_F2;
			ST_F2:    state_nx = ST_F3;
			ST_F3:    state_nx = ST_F4;
			ST_F4:    state_nx = ST_PUSH;
			ST_PUSH:  if (ph_q == 2'd2) state_nx = ST_POP;
			ST_ERD:   state_nx = ST_ELD;
			ST_ELD:   state_nx = ST_EWAIT;
			ST_EWAIT: if (m_tready) state_nx = out_last_q ? ST_LOAD : ST_ERD;
			default:  state_nx = ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = k_q;
		mem_wdata = rd_q;
		mem_raddr = k_q;
		stk_we    = 1'b0;
		stk_waddr = sp_q[IDX_W-1:0];
		stk_wdata = r_sel;
		stk_raddr = idx_t'(sp_q - cnt_t'(1));
		cmp_x     = rd_q;
		cmp_lo    = a_q;
		cmp_hi    = b_q;
		case (state_q)
			ST_LOAD: begin
				s_tready  = 1'b1;
				mem_we    = in_acc && (cnt_q < MAX_CNT);
				mem_waddr = cnt_q[IDX_W-1:0];
				mem_wdata = s_tdata;
			end
			ST_INIT: begin
				stk_we    = (cnt_q >= cnt_t'(2));
				stk_wdata = '{lo: '0, hi: idx_t'(cnt_q - cnt_t'(1))};
			end
			ST_POPW: mem_raddr = stk_rd_q.lo;
			ST_RDHI: mem_raddr = hi_q;
			ST_PIV: begin
				cmp_x     = a_q;
				cmp_hi    = rd_q;
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = cmp.gt_hi ? rd_q : a_q;
			end
			ST_PIV2: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = b_q;
			end
			ST_CMP:  mem_raddr = cmp.lt_lo ? lt_q : gt_q;
			ST_SW1: begin
				mem_we    = 1'b1;
				mem_waddr = k_q;
				mem_wdata = rd_q;
			end
			ST_SW2: begin
				mem_we    = 1'b1;
				mem_waddr = sw_lt_q ? lt_q : gt_q;
				mem_wdata = x_q;
			end
			ST_FIN:  mem_raddr = lt_q - idx_t'(1);
			ST_F1: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = rd_q;
			end
			ST_F2: begin
				mem_we    = 1'b1;
				mem_waddr = lt_q;
				mem_wdata = a_q;
				mem_raddr = gt_q;
			end
			ST_F3: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = rd_q;
			end
			ST_F4: begin
				mem_we    = 1'b1;
				mem_waddr = gt_q;
				mem_wdata = b_q;
			end
			ST_PUSH: stk_we = (span_sel != '0) && (sp_q < MAX_CNT);
			default: ;
		endcase
	end

	// Element store and range stack: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stk[stk_raddr];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_INIT:  k_q <= '0;
			ST_POP:   k_q <= '0;
			ST_POPW: begin
				lo_q <= stk_rd_q.lo;
				hi_q <= stk_rd_q.hi;
			end
			ST_RDHI:  a_q <= rd_q;
			ST_PIV: begin
				if (cmp.gt_hi) begin
					a_q <= rd_q;
					b_q <= a_q;
				end else begin
					b_q <= rd_q;
				end
				lt_q <= lo_q + idx_t'(1);
				gt_q <= hi_q - idx_t'(1);
				k_q  <= lo_q + idx_t'(1);
			end
			ST_CMP: begin
				x_q     <= rd_q;
				sw_lt_q <= cmp.lt_lo;
				if (!cmp.lt_lo && !cmp.gt_hi) begin
					k_q <= k_q + idx_t'(1);
				end
			end
			ST_SW2: begin
				if (sw_lt_q) begin
					lt_q <= lt_q + idx_t'(1);
					k_q  <= k_q + idx_t'(1);
				end else begin
					gt_q <= gt_q - idx_t'(1);
				end
			end
			ST_FIN: begin
				lt_q <= lt_q - idx_t'(1);
				gt_q <= gt_q + idx_t'(1);
			end
			ST_ELD:   out_data_q <= rd_q;
			ST_EWAIT: if (m_tready && !out_last_q) k_q <= k_q + idx_t'(1);
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			sp_q        <= '0;
			drop_q      <= 1'b0;
			ph_q        <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (cnt_q < MAX_CNT) begin
							cnt_q <= cnt_q + cnt_t'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_INIT: sp_q <= (cnt_q >= cnt_t'(2)) ? cnt_t'(1) : '0;
				ST_POP:  if (sp_q != '0) sp_q <= sp_q - cnt_t'(1);
				ST_FIN:  ph_q <= '0;
				ST_PUSH: begin
					if (stk_we) begin
						sp_q <= sp_q + cnt_t'(1);
					end
					ph_q <= ph_q + 2'd1;
				end
				ST_ELD: begin
					out_valid_q <= 1'b1;
					out_last_q  <= ({1'b0, k_q} == ext_t'(cnt_q - cnt_t'(1)));
					out_ovf_q   <= drop_q;
				end
				ST_EWAIT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/dps_chk.sv */
// Port-level checker for the dual-pivot sort engine, bound to the top level.
// Depends only on the top level's ports.
module dps_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output beat changed while stalled");

	// The engine never loads and emits at the same time.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while output beat pending");

	// The closing input beat stops loading.
	a_last_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("still loading after the last input beat");

	// Taking the final output beat reopens the input side.
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("input not reopened after the final output beat");

endmodule

bind dual_pivot_sort_engine_top dps_chk u_dps_chk (.*);
